// ===== sv/hti_pkg.sv =====
package hti_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int QPOS_W      = 18;
  localparam int IDX_W       = 8;
  localparam int EXT_W       = 9;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_W       = 16;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RNG = 3'd3;

  // derived arithmetic widths
  localparam int LIM_W  = EXT_W + FRAC_BITS;          // clamped position
  localparam int GR_W   = LIM_W - FRAC_BITS;          // cell index
  localparam int WGT_W  = FRAC_BITS + 1;              // weight 0..ONE
  localparam int DIFF_W = SAMPLE_BITS + 1;            // sample minus lowest
  localparam int PROD_W = WGT_W + 1 + DIFF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int S_W    = FRAC_BITS + 20;             // holds +/- 2^(FRAC_BITS+18)
  localparam int P_W    = S_W + CFG_W + 1;
  localparam int RSH    = FRAC_BITS + 2;
  localparam int H_W    = P_W - RSH;

  localparam logic [WGT_W-1:0]        ONE   = WGT_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] S_HI  = SUM_W'(longint'(1) << (FRAC_BITS + 18));
  localparam logic signed [SUM_W-1:0] S_LO  = -S_HI;
  localparam logic signed [P_W-1:0]   HALF  = P_W'(longint'(1) << (RSH - 1));
  localparam logic signed [H_W-1:0]   H_MAX = H_W'(32767);
  localparam logic signed [H_W-1:0]   H_MIN = -H_W'(32768);

  typedef struct packed {
    logic [WGT_W-1:0] w0;  // weight of the (row, col+1) sample
    logic [WGT_W-1:0] w1;  // weight of the (row+1, col) sample
    logic [WGT_W-1:0] w2;  // weight of the diagonal corner
  } wgt_t;

endpackage

// ===== sv/heightmap_triangle_interpolator.sv =====
// heightmap triangle interpolator: takes one item per clock, every clock (busy never rises),
// and the receiver cannot stall. a write item stores one elevation sample; a query item
// returns one normalised height through the registered pipeline below, marked by out_valid for a
// single cycle, in query order. the grid sits in four single-port-write synchronous memories
// banked by row and column parity, so the four corners of any cell come out together in the
// same registered read, ahead of the weight products and 1/range scaling, each registered. the
// grid has no reset: a query must only touch written samples. the user must write registers via
// cfg_write_en / cfg_index / cfg_data only while no query is in flight; nothing enforces it.
module heightmap_triangle_interpolator #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_operation,
  input  logic [hti_pkg::IDX_W-1:0]           in_write_row,
  input  logic [hti_pkg::IDX_W-1:0]           in_write_col,
  input  logic signed [hti_pkg::SAMPLE_BITS-1:0] in_sample_value,
  input  logic signed [hti_pkg::QPOS_W-1:0]   in_query_row,
  input  logic signed [hti_pkg::QPOS_W-1:0]   in_query_col,
  input  logic                                cfg_write_en,
  input  logic [hti_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hti_pkg::CFG_W-1:0]           cfg_data,
  output logic                                out_valid,
  output logic signed [hti_pkg::OUT_W-1:0]    out_height_normalized,
  output logic                                out_saturated
);
  import hti_pkg::*;

  // bank geometry: bank g holds rows of parity g[1] and columns of parity g[0]
  localparam int BANK_ROWS  = (MAX_ROWS + 1) / 2;
  localparam int BANK_COLS  = (MAX_COLS + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
  localparam int RB = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
  localparam int CB = (BANK_COLS > 1) ? $clog2(BANK_COLS) : 1;
  localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // extent clamped to [2, max], less two, in position units
  function automatic logic [LIM_W-1:0] pos_limit(input logic [EXT_W-1:0] ext, input int max_ext);
    int n;
    n = int'(ext);
    if (n < 2) n = 2;
    if (n > max_ext) n = max_ext;
    return LIM_W'((n - 2) << FRAC_BITS);
  endfunction

  function automatic logic [AW-1:0] bank_addr(input logic [RB-1:0] rh, input logic [CB-1:0] ch);
    return AW'(int'(rh) * BANK_COLS + int'(ch));
  endfunction

  // position clamp to the loaded grid, stripped down to a compare limit
  function automatic logic [LIM_W-1:0] clamp_pos(input logic signed [QPOS_W-1:0] q,
                                                 input logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] r;
    if (q < 0) r = '0;
    else if (q > $signed(QPOS_W'(lim))) r = lim;
    else r = q[LIM_W-1:0];
    return r;
  endfunction

  // configuration, kept in the form the datapath wants
  logic [LIM_W-1:0]              row_lim_r;
  logic [LIM_W-1:0]              col_lim_r;
  logic signed [SAMPLE_BITS-1:0] lowest_r;
  logic [CFG_W-1:0]              inv_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_lim_r   <= pos_limit(EXT_W'(256), MAX_ROWS);
      col_lim_r   <= pos_limit(EXT_W'(256), MAX_COLS);
      lowest_r    <= '0;
      inv_range_r <= CFG_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_ROWS:    row_lim_r   <= pos_limit(cfg_data[EXT_W-1:0], MAX_ROWS);
        CFG_COLS:    col_lim_r   <= pos_limit(cfg_data[EXT_W-1:0], MAX_COLS);
        CFG_LOWEST:  lowest_r    <= $signed(cfg_data[SAMPLE_BITS-1:0]);
        CFG_INV_RNG: inv_range_r <= cfg_data;
        default: ;  // unused index, nothing to do
      endcase
    end
  end

  // no interlock needed: one item per cycle, never any stall
  assign busy = 1'b0;

  logic accept;
  logic is_query;
  assign accept   = start && !busy;
  assign is_query = accept && (in_operation == OP_QUERY);

  // ---------------------------------------------------------------- stage 0: decode
  logic [LIM_W-1:0] qr_c, qc_c;
  logic [GR_W-1:0]  gr, gc;
  logic [FRAC_BITS-1:0] fr, fc;
  logic [WGT_W-1:0] fsum;
  logic             upper;
  wgt_t             wgt_nxt;

  assign qr_c  = clamp_pos(in_query_row, row_lim_r);
  assign qc_c  = clamp_pos(in_query_col, col_lim_r);
  assign gr    = qr_c[LIM_W-1:FRAC_BITS];
  assign gc    = qc_c[LIM_W-1:FRAC_BITS];
  assign fr    = qr_c[FRAC_BITS-1:0];
  assign fc    = qc_c[FRAC_BITS-1:0];
  assign fsum  = WGT_W'(fr) + WGT_W'(fc);
  assign upper = fsum[FRAC_BITS];  // fr + fc >= one

  // upper triangle: (one-fr) h2, (one-fc) h4, (fr+fc-one) h3
  // lower triangle: fc h2, fr h4, (one-fr-fc) h1
  always_comb begin
    if (upper) begin
      wgt_nxt.w0 = ONE - WGT_W'(fr);
      wgt_nxt.w1 = ONE - WGT_W'(fc);
      wgt_nxt.w2 = fsum - ONE;
    end else begin
      wgt_nxt.w0 = WGT_W'(fc);
      wgt_nxt.w1 = WGT_W'(fr);
      wgt_nxt.w2 = ONE - fsum;
    end
  end

  // bank addresses: odd-parity banks take the half index, even ones round it up
  logic [RB-1:0] rh_even, rh_odd;
  logic [CB-1:0] ch_even, ch_odd;
  assign rh_odd  = RB'(gr[GR_W-1:1]);
  assign rh_even = RB'(GR_W'(gr[GR_W-1:1]) + GR_W'(gr[0]));
  assign ch_odd  = CB'(gc[GR_W-1:1]);
  assign ch_even = CB'(GR_W'(gc[GR_W-1:1]) + GR_W'(gc[0]));

  logic            wr_ok;
  logic [1:0]      wr_bank;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr [4];
  logic [SAMPLE_BITS-1:0] rd_data [4];

  assign wr_ok   = accept && (in_operation == OP_WRITE)
                   && (int'(in_write_row) < MAX_ROWS) && (int'(in_write_col) < MAX_COLS);
  assign wr_bank = {in_write_row[0], in_write_col[0]};
  assign wr_addr = bank_addr(RB'(in_write_row[IDX_W-1:1]), CB'(in_write_col[IDX_W-1:1]));

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [SAMPLE_BITS-1:0] mem [BANK_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_q;

    assign rd_addr[g] = bank_addr((g / 2 == 1) ? rh_odd : rh_even,
                                  (g % 2 == 1) ? ch_odd : ch_even);

    always_ff @(posedge clk) begin
      if (wr_ok && (wr_bank == 2'(g))) begin
        mem[wr_addr] <= in_sample_value;
      end
      rd_q <= mem[rd_addr[g]];
    end

    assign rd_data[g] = rd_q;
  end

  // ---------------------------------------------------------------- stage 1: corner select
  logic        s1_valid_r, s1_upper_r, s1_rpar_r, s1_cpar_r;
  wgt_t        s1_wgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= is_query;
    end
    s1_upper_r <= upper;
    s1_rpar_r  <= gr[0];
    s1_cpar_r  <= gc[0];
    s1_wgt_r   <= wgt_nxt;
  end

  logic signed [SAMPLE_BITS-1:0] h1, h2, h3, h4, hdiag;
  assign h1    = $signed(rd_data[{s1_rpar_r, s1_cpar_r}]);
  assign h2    = $signed(rd_data[{s1_rpar_r, ~s1_cpar_r}]);
  assign h4    = $signed(rd_data[{~s1_rpar_r, s1_cpar_r}]);
  assign h3    = $signed(rd_data[{~s1_rpar_r, ~s1_cpar_r}]);
  assign hdiag = s1_upper_r ? h3 : h1;

  logic signed [DIFF_W-1:0] x0_nxt, x1_nxt, x2_nxt;
  assign x0_nxt = DIFF_W'(h2) - DIFF_W'(lowest_r);
  assign x1_nxt = DIFF_W'(h4) - DIFF_W'(lowest_r);
  assign x2_nxt = DIFF_W'(hdiag) - DIFF_W'(lowest_r);

  // ---------------------------------------------------------------- stage 2: weight products
  logic                     s2_valid_r;
  logic signed [DIFF_W-1:0] s2_x0_r, s2_x1_r, s2_x2_r;
  wgt_t                     s2_wgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_x0_r  <= x0_nxt;
    s2_x1_r  <= x1_nxt;
    s2_x2_r  <= x2_nxt;
    s2_wgt_r <= s1_wgt_r;
  end

  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, p2_nxt;
  assign p0_nxt = $signed({1'b0, s2_wgt_r.w0}) * s2_x0_r;
  assign p1_nxt = $signed({1'b0, s2_wgt_r.w1}) * s2_x1_r;
  assign p2_nxt = $signed({1'b0, s2_wgt_r.w2}) * s2_x2_r;

  // ---------------------------------------------------------------- stage 3: sum and clamp
  logic                     s3_valid_r;
  logic signed [PROD_W-1:0] s3_p0_r, s3_p1_r, s3_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_p0_r <= p0_nxt;
    s3_p1_r <= p1_nxt;
    s3_p2_r <= p2_nxt;
  end

  logic signed [SUM_W-1:0] sum_raw, sum_clamped;
  assign sum_raw = SUM_W'(s3_p0_r) + SUM_W'(s3_p1_r) + SUM_W'(s3_p2_r);

  always_comb begin
    if (sum_raw > S_HI)      sum_clamped = S_HI;
    else if (sum_raw < S_LO) sum_clamped = S_LO;
    else                     sum_clamped = sum_raw;
  end

  // ---------------------------------------------------------------- stage 4: scale by 1/range
  logic                  s4_valid_r;
  logic signed [S_W-1:0] s4_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_sum_r <= S_W'(sum_clamped);
  end

  logic signed [P_W-1:0] scaled_nxt;
  assign scaled_nxt = P_W'(s4_sum_r) * $signed({1'b0, inv_range_r});

  // ---------------------------------------------------------------- stage 5: round, saturate
  logic                  s5_valid_r;
  logic signed [P_W-1:0] s5_scaled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
    s5_scaled_r <= scaled_nxt;
  end

  // nearest, ties toward +inf: add half then floor
  logic signed [P_W-1:0] rounded;
  logic signed [H_W-1:0] h_full;
  logic signed [OUT_W-1:0] height_nxt;
  logic                    sat_nxt;

  assign rounded = s5_scaled_r + HALF;
  assign h_full  = H_W'(rounded >>> RSH);

  always_comb begin
    if (h_full > H_MAX) begin
      height_nxt = OUT_W'(H_MAX);
      sat_nxt    = 1'b1;
    end else if (h_full < H_MIN) begin
      height_nxt = OUT_W'(H_MIN);
      sat_nxt    = 1'b1;
    end else begin
      height_nxt = OUT_W'(h_full);
      sat_nxt    = 1'b0;
    end
  end

  // ---------------------------------------------------------------- output register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_height_r;
  logic                    out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s5_valid_r;
    end
    out_height_r <= height_nxt;
    out_sat_r    <= sat_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_height_normalized = out_height_r;
  assign out_saturated         = out_sat_r;

endmodule

// ===== sv/hti_checker.sv =====
module hti_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             in_operation,
  input logic                             out_valid,
  input logic signed [hti_pkg::OUT_W-1:0] out_height_normalized,
  input logic                             out_saturated
);
  import hti_pkg::*;

  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(32767);
  localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_W'(32768);

  logic q_acc;
  assign q_acc = rst_n && start && !busy && (in_operation == OP_QUERY);

  // every result traces back to an accepted query transfer
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(q_acc, 6))
    else $error("result without a matching query transfer");

  // and no query is dropped while reset stays away
  a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(q_acc, 6) && $past(rst_n, 5) && $past(rst_n, 4) && $past(rst_n, 3)
    && $past(rst_n, 2) && $past(rst_n, 1) |-> out_valid)
    else $error("query transfer produced no result");

  // a clipped height sits on a rail
  a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated
    |-> (out_height_normalized == OUT_MAX) || (out_height_normalized == OUT_MIN))
    else $error("saturation flag with an unclipped height");

  // the pipeline never holds the input side off
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("busy raised against a start");

endmodule

bind heightmap_triangle_interpolator hti_checker u_hti_checker (.*);
